>>> rtl/core/unordered_set_table_assert.svh
// ----------------------------------------------------------------------------
// unordered_set_table assertion macros
// Shorthand for clocked implication checks. The user's scope supplies the
// clk and rst names.
// ----------------------------------------------------------------------------
`ifndef UNORDERED_SET_TABLE_ASSERT_SVH
`define UNORDERED_SET_TABLE_ASSERT_SVH

// Same-cycle implication.
`define UST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ust_pkg.sv
// ----------------------------------------------------------------------------
// ust_pkg
// Shared constants and types for the unordered set table.
// ----------------------------------------------------------------------------
`default_nettype none

package ust_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned ITEM_W          = 32;
  localparam int unsigned SIZE_W          = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_PRESENT   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Scan token passed from cell to cell.
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       found;
  } tok_t;

endpackage

`default_nettype wire

>>> rtl/core/ust_cell.sv
// ----------------------------------------------------------------------------
// ust_cell
// One slot of the store. Compares the passing token's value with its entry,
// applies insert or erase, and forwards the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ust_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned VALUE_WIDTH = ust_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CNT_W-1:0]       count,
  input  ust_pkg::tok_t          tok_in,
  input  logic [VALUE_WIDTH-1:0] val_in,
  input  logic [VALUE_WIDTH-1:0] nb_entry,
  output ust_pkg::tok_t          tok_out,
  output logic [VALUE_WIDTH-1:0] val_out,
  output logic [VALUE_WIDTH-1:0] entry
);
  import ust_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic live;
  logic hit;
  logic found_here;

  assign live       = MY_IDX < count;
  assign hit        = tok_in.valid && live && (entry == val_in);
  assign found_here = tok_in.found | hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.op    <= tok_in.op;
      tok_out.found <= found_here;
    end
  end

  always_ff @(posedge clk) begin
    val_out <= val_in;
  end

  // Erase closes the gap: every slot from the match onwards takes its
  // neighbour's entry as the token passes. The neighbour is still untouched.
  // Insert lands in the first free slot; by then all live slots are scanned.
  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      if (tok_in.op == OP_ERASE && found_here) begin
        entry <= nb_entry;
      end else if (tok_in.op == OP_INSERT && MY_IDX == count && !tok_in.found) begin
        entry <= val_in;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ust_ctrl.sv
// ----------------------------------------------------------------------------
// ust_ctrl
// Command intake, live count and result register. Launches one token into
// the cell row per item and closes the item when the token leaves the row.
// ----------------------------------------------------------------------------
`default_nettype none

module ust_ctrl #(
  parameter int unsigned CAPACITY    = ust_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = ust_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [ust_pkg::ITEM_W-1:0]  item_value,
  output ust_pkg::tok_t               head_tok,
  output logic [VALUE_WIDTH-1:0]      head_val,
  input  ust_pkg::tok_t               tail_tok,
  output logic [CNT_W-1:0]            count,
  output logic                        done,
  output logic [1:0]                  status,
  output logic                        was_present,
  output logic [ust_pkg::SIZE_W-1:0]  set_size
);
  import ust_pkg::*;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic                          accept;
  logic [ITEM_W+VALUE_WIDTH-1:0] val_ext;
  logic [1:0]                    st_next;
  logic [CNT_W-1:0]              count_next;
  logic [CNT_W+SIZE_W-1:0]       size_ext;

  assign accept   = start && !busy;
  assign val_ext  = {{VALUE_WIDTH{1'b0}}, item_value};
  assign size_ext = {{SIZE_W{1'b0}}, count_next};

  always_comb begin
    st_next    = ST_NOT_FOUND;
    count_next = count;
    case (tail_tok.op)
      OP_INSERT: begin
        if (tail_tok.found) begin
          st_next = ST_PRESENT;
        end else if (count == CAP_C) begin
          st_next = ST_FULL;
        end else begin
          st_next    = ST_DONE;
          count_next = count + ONE_C;
        end
      end
      OP_ERASE: begin
        if (tail_tok.found) begin
          st_next    = ST_DONE;
          count_next = count - ONE_C;
        end
      end
      default: begin
        // query, and the unused code with it
        st_next = tail_tok.found ? ST_DONE : ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      head_tok <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      done           <= tail_tok.valid;
      head_tok.valid <= accept;
      head_tok.op    <= opcode;
      head_tok.found <= 1'b0;
      if (accept) begin
        busy <= 1'b1;
      end
      if (tail_tok.valid) begin
        busy  <= 1'b0;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_val <= val_ext[VALUE_WIDTH-1:0];
    end
    if (tail_tok.valid) begin
      status      <= st_next;
      was_present <= tail_tok.found;
      set_size    <= size_ext[SIZE_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/unordered_set_table.sv
// ----------------------------------------------------------------------------
// unordered_set_table
// Fixed-capacity set of distinct values with insert, erase and membership.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result appears. Each item walks a scan token down a row of
// CAPACITY cells, one cell per clock, and the next item can be taken only
// once the result of the last one appears, whatever the opcode. The
// result shows on status, was_present and set_size for exactly one cycle
// with done high; it cannot be held off, so the receiver must take it then.
// Values wider than VALUE_WIDTH are truncated; above 127 entries set_size
// wraps to its low 7 bits.
`default_nettype none

module unordered_set_table #(
  parameter int unsigned CAPACITY    = ust_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = ust_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode,
  input  logic [ust_pkg::ITEM_W-1:0] item_value,
  output logic                       done,
  output logic [1:0]                 status,
  output logic                       was_present,
  output logic [ust_pkg::SIZE_W-1:0] set_size
);
  import ust_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  tok_t                   tok_chain [0:CAPACITY];
  logic [VALUE_WIDTH-1:0] val_chain [0:CAPACITY-1];
  logic [VALUE_WIDTH-1:0] entries   [0:CAPACITY-1];
  logic [CNT_W-1:0]       count;

  ust_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .item_value  (item_value),
    .head_tok    (tok_chain[0]),
    .head_val    (val_chain[0]),
    .tail_tok    (tok_chain[CAPACITY]),
    .count       (count),
    .done        (done),
    .status      (status),
    .was_present (was_present),
    .set_size    (set_size)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i < CAPACITY - 1) begin : g_mid
      ust_cell #(
        .IDX         (i),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .count    (count),
        .tok_in   (tok_chain[i]),
        .val_in   (val_chain[i]),
        .nb_entry (entries[i+1]),
        .tok_out  (tok_chain[i+1]),
        .val_out  (val_chain[i+1]),
        .entry    (entries[i])
      );
    end else begin : g_last
      // last slot has no right neighbour; after an erase it is no longer live
      ust_cell #(
        .IDX         (i),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .count    (count),
        .tok_in   (tok_chain[i]),
        .val_in   (val_chain[i]),
        .nb_entry (entries[i]),
        .tok_out  (tok_chain[i+1]),
        .val_out  (),
        .entry    (entries[i])
      );
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ust_checker.sv
// ----------------------------------------------------------------------------
// ust_checker
// Port-level checks on the unordered set table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unordered_set_table_assert.svh"

module ust_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic [1:0]                 status,
  input wire logic                       was_present,
  input wire logic [ust_pkg::SIZE_W-1:0] set_size
);
  import ust_pkg::*;

  `UST_ASSERT_NXT(a_take_busy, start && !busy, busy, "item taken but busy not raised")
  `UST_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")
  `UST_ASSERT_NXT(a_done_once, done, !done, "result strobe longer than one cycle")
  `UST_ASSERT_IMP(a_present_st, done && was_present,
    status == ST_DONE || status == ST_PRESENT, "present value with wrong status")
  // a duplicate or a full store leaves the size as the previous item left it
  `UST_ASSERT_IMP(a_size_steady, done && (status == ST_FULL || status == ST_PRESENT),
    set_size == $past(set_size), "size changed on a rejected insert")

endmodule

bind unordered_set_table ust_checker u_ust_checker (.*);

`default_nettype wire
